>>> sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the barometric sensor compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int COEF_W    = 16;
   localparam int RAW_W     = 24;
   localparam int DT_W      = 25;
   localparam int VALUE_W   = 32;
   localparam int CSR_IDX_W = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_SENS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFF      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TCS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TCO      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TREF     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TEMPSENS = 3'd5;

   localparam logic KIND_TEMP = 1'b0;
   localparam logic KIND_PRES = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_TEMP = 1'b1;

   // Serial multiplier: signed multiplicand, unsigned multiplier taken one
   // digit per cycle, least significant digit first.
   localparam int MUL_A_W    = 35;
   localparam int MUL_B_W    = 24;
   localparam int DIGIT_W    = 4;
   localparam int MUL_STEPS  = MUL_B_W / DIGIT_W;
   localparam int STEP_CNT_W = $clog2(MUL_STEPS);
   localparam int HI_W       = MUL_A_W + 1;
   localparam int SUM_W      = HI_W + DIGIT_W;
   localparam int PROD_W     = HI_W + MUL_B_W;

   localparam int TEMP_BASE = 2000;

   typedef struct packed {
      logic             kind;
      logic [RAW_W-1:0] raw_sample;
   } req_type;

   typedef struct packed {
      logic                      result_kind;
      logic signed [VALUE_W-1:0] value;
      logic                      status;
   } rsp_type;

   typedef struct packed {
      logic [COEF_W-1:0] sens;
      logic [COEF_W-1:0] off;
      logic [COEF_W-1:0] tcs;
      logic [COEF_W-1:0] tco;
      logic [COEF_W-1:0] tref;
      logic [COEF_W-1:0] tempsens;
   } coef_type;

   typedef struct packed {
      logic                      start;
      logic signed [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0]        b;
   } mul_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [PROD_W-1:0] product;
   } mul_rsp_type;

endpackage

>>> sv/bsc_csr_regs.sv
// ----------------------------------------------------------------------------
// bsc_csr_regs
// Calibration coefficient registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bsc_csr_regs import bsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata,
   output coef_type             coef
);

   coef_type coef_ff;
   coef_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SENS:     coef_in.sens     = csr_wdata;
            REG_OFF:      coef_in.off      = csr_wdata;
            REG_TCS:      coef_in.tcs      = csr_wdata;
            REG_TCO:      coef_in.tco      = csr_wdata;
            REG_TREF:     coef_in.tref     = csr_wdata;
            REG_TEMPSENS: coef_in.tempsens = csr_wdata;
            default:      coef_in          = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

>>> sv/bsc_serial_mul.sv
// ----------------------------------------------------------------------------
// bsc_serial_mul
// Digit-serial signed by unsigned multiplier, one multiplier digit per cycle.
// ----------------------------------------------------------------------------
module bsc_serial_mul import bsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic signed [MUL_A_W-1:0] a_ff, a_in;
   logic signed [HI_W-1:0]    hi_ff, hi_in;
   logic [MUL_B_W-1:0]        lo_ff, lo_in;
   logic [STEP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic signed [SUM_W-1:0]   part_w;
   logic signed [SUM_W-1:0]   sum_w;

   // The low register starts with the multiplier and fills with product bits
   // from the top while its digits are consumed from the bottom.
   always_comb begin
      part_w = SUM_W'(a_ff) * SUM_W'($signed({1'b0, lo_ff[DIGIT_W-1:0]}));
      sum_w  = SUM_W'(hi_ff) + part_w;

      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (mul_req.start) begin
         a_in    = mul_req.a;
         hi_in   = '0;
         lo_in   = mul_req.b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum_w[SUM_W-1:DIGIT_W];
         lo_in  = {sum_w[DIGIT_W-1:0], lo_ff[MUL_B_W-1:DIGIT_W]};
         cnt_in = cnt_ff + STEP_CNT_W'(1);
         if (cnt_ff == STEP_CNT_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign mul_rsp.busy    = busy_ff;
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = {hi_ff, lo_ff};

endmodule

>>> sv/baro_sensor_compensation.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// First-order temperature and pressure compensation of raw sensor words.
// ----------------------------------------------------------------------------
// The digit-serial multiplier is shared: a temperature word needs one product,
// a pressure word three, and a pressure word seen before any temperature word
// none. A new word is taken only in idle, after the last result has been loaded
// into the output register, so an output stall also holds off the next word.
// Synchronous reset clears coefficients, the kept temperature difference and
// all control state.
module baro_sensor_compensation import bsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TEMP = 3'd1;
   localparam logic [2:0] S_OFF  = 3'd2;
   localparam logic [2:0] S_SENS = 3'd3;
   localparam logic [2:0] S_PRES = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   coef_type    coef;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   logic [2:0]                state_ff, state_in;
   logic                      kind_ff, kind_in;
   logic [RAW_W-1:0]          raw_ff, raw_in;
   logic signed [DT_W-1:0]    dt_ff, dt_in;
   logic                      dt_valid_ff, dt_valid_in;
   logic signed [MUL_A_W-1:0] off_ff, off_in;
   rsp_type                   res_ff, res_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      req_fire;
   logic                      rsp_load;
   logic signed [DT_W-1:0]    new_dt_w;
   logic signed [MUL_A_W-1:0] sens_w;
   logic signed [SUM_W+2:0]   pdiff_w;

   bsc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   bsc_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      new_dt_w = $signed({1'b0, req_data.raw_sample}) - $signed({1'b0, coef.tref, 8'h00});
      sens_w   = $signed({4'b0000, coef.sens, 15'h0000})
               + mul_rsp.product[MUL_A_W+7:8];
      // Pressure: floor(raw*SENS / 2^21) - OFF, later shifted by 15.
      pdiff_w  = (SUM_W+3)'($signed(mul_rsp.product[PROD_W-1:21]))
               - (SUM_W+3)'(off_ff);
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      raw_in      = raw_ff;
      dt_in       = dt_ff;
      dt_valid_in = dt_valid_ff;
      off_in      = off_ff;
      res_in      = res_ff;
      mul_req     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in = req_data.kind;
               raw_in  = req_data.raw_sample;
               res_in.result_kind = req_data.kind;
               res_in.status      = STATUS_OK;
               if (req_data.kind == KIND_TEMP) begin
                  dt_in         = new_dt_w;
                  dt_valid_in   = 1'b1;
                  mul_req.start = 1'b1;
                  mul_req.a     = MUL_A_W'(new_dt_w);
                  mul_req.b     = MUL_B_W'(coef.tempsens);
                  state_in      = S_TEMP;
               end else if (!dt_valid_ff) begin
                  res_in.value  = '0;
                  res_in.status = STATUS_NO_TEMP;
                  state_in      = S_OUT;
               end else begin
                  mul_req.start = 1'b1;
                  mul_req.a     = MUL_A_W'(dt_ff);
                  mul_req.b     = MUL_B_W'(coef.tco);
                  state_in      = S_OFF;
               end
            end
         end
         S_TEMP: begin
            if (mul_rsp.done) begin
               res_in.value = $signed(mul_rsp.product[VALUE_W+22:23])
                            + VALUE_W'(TEMP_BASE);
               state_in     = S_OUT;
            end
         end
         S_OFF: begin
            if (mul_rsp.done) begin
               off_in        = $signed({3'b000, coef.off, 16'h0000})
                             + mul_rsp.product[MUL_A_W+6:7];
               mul_req.start = 1'b1;
               mul_req.a     = MUL_A_W'(dt_ff);
               mul_req.b     = MUL_B_W'(coef.tcs);
               state_in      = S_SENS;
            end
         end
         S_SENS: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a     = sens_w;
               mul_req.b     = raw_ff;
               state_in      = S_PRES;
            end
         end
         S_PRES: begin
            if (mul_rsp.done) begin
               res_in.value = VALUE_W'($signed(pdiff_w[SUM_W+2:15]));
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dt_ff        <= '0;
         dt_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dt_ff        <= dt_in;
         dt_valid_ff  <= dt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      raw_ff  <= raw_in;
      off_ff  <= off_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The multiplier only runs while the sequencer waits on a product.
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_OUT) |-> !mul_rsp.busy)
      else $error("multiplier busy outside a multiply state");

   a_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_TEMP || state_ff == S_OFF ||
                        state_ff == S_SENS || state_ff == S_PRES))
      else $error("product finished with no one waiting");

   a_temp_kept: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.kind == KIND_TEMP) |=> dt_valid_ff)
      else $error("temperature difference not kept");

   a_no_temp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_NO_TEMP) |->
         (rsp_data.value == '0 && rsp_data.result_kind == KIND_PRES))
      else $error("bad result for pressure without temperature");

   a_kind_match: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (res_ff.result_kind == kind_ff))
      else $error("result kind differs from request kind");

endmodule
